// File: design/ism_pkg.sv
// Shared types and codes for the interval set merge and query block.
package ism_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_FINISH = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_FULL         = 2'd1,
        ST_NOT_FINISHED = 2'd2
    } t_status;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

// File: design/ism_req_if.sv
// Request channel carrying one operation and its operands.
interface ism_req_if import ism_pkg::*; #(
    parameter int KEY_BITS = 31
);
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [KEY_BITS-1:0] range_start;
    logic [KEY_BITS-1:0] range_end;
    logic [KEY_BITS-1:0] probe_key;

    modport source (output valid, output op, output range_start, output range_end,
                    output probe_key, input ready);
    modport sink   (input valid, input op, input range_start, input range_end,
                    input probe_key, output ready);
endinterface

// File: design/ism_rsp_if.sv
// Response channel carrying the status, query answer and entry count.
interface ism_rsp_if import ism_pkg::*; #(
    parameter int KEY_BITS = 31,
    parameter int CNT_W    = 7
);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [KEY_BITS-1:0] next_member;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, output status, output hit, output next_member,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input hit, input next_member,
                    input entry_count, output ready);
endinterface

// File: design/ism_cell.sv
// One storage cell of the sorted interval chain with its local compares.
module ism_cell import ism_pkg::*; #(
    parameter int KEY_BITS = 31,
    parameter int CNT_W    = 7,
    parameter int IDX      = 0
) (
    input  logic                i_clk,
    input  t_cell_ctl           i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [CNT_W-1:0]    i_cursor,
    input  logic [KEY_BITS-1:0] i_new_s,
    input  logic [KEY_BITS-1:0] i_new_e,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [KEY_BITS-1:0] i_succ,
    input  logic [KEY_BITS-1:0] i_left_s,
    input  logic [KEY_BITS-1:0] i_left_e,
    input  logic                i_left_lt,
    input  logic                i_left_gt,
    input  logic [KEY_BITS-1:0] i_right_s,
    input  logic [KEY_BITS-1:0] i_right_e,
    output logic [KEY_BITS-1:0] o_s,
    output logic [KEY_BITS-1:0] o_e,
    output logic                o_lt,
    output logic                o_gt,
    output logic                o_ov,
    output logic                o_hit,
    output logic                o_inv,
    output logic                o_sel,
    output logic [KEY_BITS-1:0] o_sel_start
);

    localparam logic [CNT_W-1:0] MY_IDX   = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_IDX = CNT_W'(IDX + 1);

    logic [KEY_BITS-1:0] r_s;
    logic [KEY_BITS-1:0] r_e;
    logic                w_valid;
    logic                w_rvalid;

    assign w_valid  = MY_IDX < i_count;
    assign w_rvalid = NEXT_IDX < i_count;

    assign o_s  = r_s;
    assign o_e  = r_e;
    // An empty cell sorts above every interval.
    assign o_lt = !w_valid || (i_new_s < r_s) || ((i_new_s == r_s) && (i_new_e < r_e));
    assign o_gt = w_valid && (r_s > i_succ);
    assign o_ov = w_rvalid && (r_e >= i_right_s);

    assign o_hit       = w_valid && (r_s <= i_key) && (i_key < r_e);
    assign o_inv       = w_valid && (r_s <= i_succ) && (i_succ < r_e);
    assign o_sel       = o_gt && !i_left_gt;
    assign o_sel_start = o_sel ? r_s : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && o_lt) begin
            if (i_left_lt) begin
                r_s <= i_left_s;
                r_e <= i_left_e;
            end else begin
                r_s <= i_new_s;
                r_e <= i_new_e;
            end
        end else if (i_ctl.del) begin
            if (MY_IDX == i_cursor) begin
                r_e <= (i_right_e > r_e) ? i_right_e : r_e;
            end else if (MY_IDX > i_cursor) begin
                r_s <= i_right_s;
                r_e <= i_right_e;
            end
        end
    end

endmodule

// File: design/interval_set_merge_query_core.sv
// Top level of the interval set with sorted insert, merge and membership query.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------
//   i_req    | in  | op, range_start, range_end, probe_key
//   o_rsp    | out | status, hit, next_member, entry_count
//
// Clear and add pass through the execute state to the response state; finish steps a cursor
// along the cell chain, one cursor step or one merge per cycle, until it reaches the last
// interval held.
// Query waits in the query state for the result of the registered reduction tree.
// One request is worked on at a time; a new one is taken once the response is registered.
// The synchronous reset empties the set; a stalled response holds in the output register.
module interval_set_merge_query_core import ism_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 31
) (
    input logic      i_clk,
    input logic      i_rst_n,
    ism_req_if.sink  i_req,
    ism_rsp_if.source o_rsp
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEAVES   = 1 << IDX_W;
    localparam int NODES    = 2 * LEAVES - 1;
    localparam int WAIT_W   = $clog2(IDX_W + 2);
    localparam logic [WAIT_W-1:0]   WAIT_END = WAIT_W'(IDX_W + 1);
    localparam logic [CNT_W-1:0]    CAP_C    = CNT_W'(CAPACITY);
    localparam logic [KEY_BITS-1:0] KEY_MAX  = {KEY_BITS{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MERGE,
        S_QUERY,
        S_RESP
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [KEY_BITS-1:0] r_s;
    logic [KEY_BITS-1:0] r_e;
    logic [KEY_BITS-1:0] r_key;
    logic [CNT_W-1:0]    r_count;
    logic                r_merged;
    logic [IDX_W-1:0]    r_cursor;
    logic [WAIT_W-1:0]   r_wait;

    t_status             r_res_status;
    logic                r_res_hit;
    logic [KEY_BITS-1:0] r_res_next;
    logic [CNT_W-1:0]    r_res_count;

    logic                r_out_valid;
    t_status             r_out_status;
    logic                r_out_hit;
    logic [KEY_BITS-1:0] r_out_next;
    logic [CNT_W-1:0]    r_out_count;

    logic                r_t_hit [NODES];
    logic                r_t_inv [NODES];
    logic                r_t_fnd [NODES];
    logic [KEY_BITS-1:0] r_t_nxt [NODES];

    t_cell_ctl           w_ctl;
    logic [KEY_BITS-1:0] w_succ;
    logic [CNT_W-1:0]    w_cur_next;
    logic                w_cur_ov;
    logic                w_add_ok;
    logic                w_full;

    logic [KEY_BITS-1:0] w_s       [CAPACITY];
    logic [KEY_BITS-1:0] w_e       [CAPACITY];
    logic [KEY_BITS-1:0] w_sel_s   [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_gt;
    logic [CAPACITY-1:0] w_ov;
    logic [CAPACITY-1:0] w_hit;
    logic [CAPACITY-1:0] w_inv;
    logic [CAPACITY-1:0] w_sel;

    logic [LEAVES-1:0]   w_leaf_hit;
    logic [LEAVES-1:0]   w_leaf_inv;
    logic [LEAVES-1:0]   w_leaf_fnd;
    logic [KEY_BITS-1:0] w_leaf_nxt [LEAVES];

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.next_member = r_out_next;
    assign o_rsp.entry_count = r_out_count;

    assign w_succ     = r_key + KEY_BITS'(1);
    assign w_cur_next = CNT_W'(r_cursor) + CNT_W'(1);
    assign w_cur_ov   = w_ov[r_cursor];
    assign w_add_ok   = r_s < r_e;
    assign w_full     = r_count >= CAP_C;

    assign w_ctl.ins = (r_state == S_EXEC) && (r_op == OP_ADD) && w_add_ok && !w_full;
    assign w_ctl.del = (r_state == S_MERGE) && (w_cur_next < r_count) && w_cur_ov;

    for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
        ism_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W),
            .IDX      (c)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_count     (r_count),
            .i_cursor    (CNT_W'(r_cursor)),
            .i_new_s     (r_s),
            .i_new_e     (r_e),
            .i_key       (r_key),
            .i_succ      (w_succ),
            .i_left_s    ((c == 0) ? '0 : w_s[(c == 0) ? 0 : c - 1]),
            .i_left_e    ((c == 0) ? '0 : w_e[(c == 0) ? 0 : c - 1]),
            .i_left_lt   ((c == 0) ? 1'b0 : w_lt[(c == 0) ? 0 : c - 1]),
            .i_left_gt   ((c == 0) ? 1'b0 : w_gt[(c == 0) ? 0 : c - 1]),
            .i_right_s   (w_s[(c == CAPACITY - 1) ? c : c + 1]),
            .i_right_e   (w_e[(c == CAPACITY - 1) ? c : c + 1]),
            .o_s         (w_s[c]),
            .o_e         (w_e[c]),
            .o_lt        (w_lt[c]),
            .o_gt        (w_gt[c]),
            .o_ov        (w_ov[c]),
            .o_hit       (w_hit[c]),
            .o_inv       (w_inv[c]),
            .o_sel       (w_sel[c]),
            .o_sel_start (w_sel_s[c])
        );
    end

    for (genvar c = 0; c < LEAVES; c++) begin : g_leaf
        if (c < CAPACITY) begin : g_used
            assign w_leaf_hit[c] = w_hit[c];
            assign w_leaf_inv[c] = w_inv[c];
            assign w_leaf_fnd[c] = w_sel[c];
            assign w_leaf_nxt[c] = w_sel_s[c];
        end else begin : g_pad
            assign w_leaf_hit[c] = 1'b0;
            assign w_leaf_inv[c] = 1'b0;
            assign w_leaf_fnd[c] = 1'b0;
            assign w_leaf_nxt[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < LEAVES - 1; j++) begin
            r_t_hit[j] <= r_t_hit[2 * j + 1] | r_t_hit[2 * j + 2];
            r_t_inv[j] <= r_t_inv[2 * j + 1] | r_t_inv[2 * j + 2];
            r_t_fnd[j] <= r_t_fnd[2 * j + 1] | r_t_fnd[2 * j + 2];
            r_t_nxt[j] <= r_t_nxt[2 * j + 1] | r_t_nxt[2 * j + 2];
        end
        for (int c = 0; c < LEAVES; c++) begin
            r_t_hit[LEAVES - 1 + c] <= w_leaf_hit[c];
            r_t_inv[LEAVES - 1 + c] <= w_leaf_inv[c];
            r_t_fnd[LEAVES - 1 + c] <= w_leaf_fnd[c];
            r_t_nxt[LEAVES - 1 + c] <= w_leaf_nxt[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_merged    <= 1'b1;
            r_out_valid <= 1'b0;
            r_cursor    <= '0;
            r_wait      <= '0;
        end else begin
            if (r_out_valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op     <= t_op'(i_req.op);
                        r_s      <= i_req.range_start;
                        r_e      <= i_req.range_end;
                        r_key    <= i_req.probe_key;
                        r_cursor <= '0;
                        r_wait   <= '0;
                        unique case (t_op'(i_req.op))
                            OP_CLEAR, OP_ADD: r_state <= S_EXEC;
                            OP_FINISH:        r_state <= S_MERGE;
                            OP_QUERY:         r_state <= S_QUERY;
                            default:          r_state <= S_IDLE;
                        endcase
                    end
                end
                S_EXEC: begin
                    r_res_hit  <= 1'b0;
                    r_res_next <= '0;
                    if (r_op == OP_CLEAR) begin
                        r_res_status <= ST_OK;
                        r_count      <= '0;
                        r_merged     <= 1'b1;
                        r_res_count  <= '0;
                    end else if (w_add_ok && !w_full) begin
                        r_res_status <= ST_OK;
                        r_count      <= r_count + CNT_W'(1);
                        r_merged     <= 1'b0;
                        r_res_count  <= r_count + CNT_W'(1);
                    end else begin
                        r_res_status <= w_add_ok ? ST_FULL : ST_OK;
                        r_res_count  <= r_count;
                    end
                    r_state <= S_RESP;
                end
                S_MERGE: begin
                    r_res_status <= ST_OK;
                    r_res_hit    <= 1'b0;
                    r_res_next   <= '0;
                    if (w_cur_next >= r_count) begin
                        r_merged    <= 1'b1;
                        r_res_count <= r_count;
                        r_state     <= S_RESP;
                    end else if (w_cur_ov) begin
                        r_count <= r_count - CNT_W'(1);
                    end else begin
                        r_cursor <= r_cursor + IDX_W'(1);
                    end
                end
                S_QUERY: begin
                    if (r_wait == WAIT_END) begin
                        r_res_count <= r_count;
                        if (!r_merged) begin
                            r_res_status <= ST_NOT_FINISHED;
                            r_res_hit    <= 1'b0;
                            r_res_next   <= KEY_MAX;
                        end else begin
                            r_res_status <= ST_OK;
                            r_res_hit    <= r_t_hit[0];
                            if (r_key == KEY_MAX) begin
                                r_res_next <= KEY_MAX;
                            end else if (r_t_inv[0]) begin
                                r_res_next <= w_succ;
                            end else if (r_t_fnd[0]) begin
                                r_res_next <= r_t_nxt[0];
                            end else begin
                                r_res_next <= KEY_MAX;
                            end
                        end
                        r_state <= S_RESP;
                    end else begin
                        r_wait <= r_wait + WAIT_W'(1);
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_hit    <= r_res_hit;
                        r_out_next   <= r_res_next;
                        r_out_count  <= r_res_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("held count exceeds capacity");

    a_merge_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.del |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("merge of two intervals did not reduce the count");

    a_one_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_sel))
        else $error("more than one cell claims the next start");

    a_no_ins_del: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_ctl.ins && w_ctl.del))
        else $error("insert and merge shift at once");

    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_state != S_IDLE)
        else $error("accepted request did not start work");
`endif

endmodule
